// ===== hdl/cata_pkg.sv =====
package cata_pkg;

	// 3-bit nucleotide code; T and U share a code
	typedef logic [2:0] base_code_t;

	localparam base_code_t CODE_A     = 3'd0;
	localparam base_code_t CODE_C     = 3'd1;
	localparam base_code_t CODE_G     = 3'd2;
	localparam base_code_t CODE_T     = 3'd3;
	localparam base_code_t CODE_OTHER = 3'd4;

	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_G    = 8'h47;
	localparam logic [7:0] CH_T    = 8'h54;
	localparam logic [7:0] CH_U    = 8'h55;
	localparam logic [7:0] CH_X    = 8'h58;
	localparam logic [7:0] CH_STOP = 8'h2A;

	localparam logic [1:0] FRAME_MAX = 2'd2;

	// configuration register indexes
	localparam logic REG_FRAME = 1'b0;
	localparam logic REG_STOP  = 1'b1;

	// standard genetic code, index {b0, b1, b2} with A=0 C=1 G=2 T=3
	localparam logic [0:63][7:0] AMINO_TABLE =
		"KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV*Y*YSSSS*CWCLFLF";

	typedef struct packed {
		logic       en;
		logic       idx;
		logic [1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic       vld;
		logic [7:0] amino;
		logic       has;
		logic       eos;
	} res_t;

	function automatic base_code_t base_encode(input logic [7:0] ch);
		base_code_t c;
		case (ch)
			CH_A:    c = CODE_A;
			CH_C:    c = CODE_C;
			CH_G:    c = CODE_G;
			CH_T:    c = CODE_T;
			CH_U:    c = CODE_T;
			default: c = CODE_OTHER;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] amino_lookup(input base_code_t b0, input base_code_t b1,
		input base_code_t b2);
		logic [5:0] idx;
		idx = {b0[1:0], b1[1:0], b2[1:0]};
		if (b0 == CODE_OTHER || b1 == CODE_OTHER || b2 == CODE_OTHER)
			return CH_X;
		return AMINO_TABLE[idx];
	endfunction

endpackage

// ===== hdl/cata_codon.sv =====
module cata_codon
	import cata_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_wr_t    cfg,
	input  logic       vld_s1,
	input  base_code_t code_s1,
	input  logic       last_s1,
	input  logic       out_rdy,
	output logic       adv,
	output res_t       res
);

	logic [1:0] frame_q;
	logic       stop_mode_q;
	logic [1:0] skip_q;
	logic [1:0] phase_q;
	base_code_t held0_q;
	base_code_t held1_q;
	logic       stopped_q;

	logic [1:0] skip_d;
	logic [1:0] phase_d;
	base_code_t held0_d;
	base_code_t held1_d;
	logic       stopped_d;
	logic       emit;
	logic [7:0] aa;
	logic [1:0] frame_sat;

	assign frame_sat = (cfg.data > FRAME_MAX) ? FRAME_MAX : cfg.data;

	always_comb begin
		skip_d    = skip_q;
		phase_d   = phase_q;
		held0_d   = held0_q;
		held1_d   = held1_q;
		stopped_d = stopped_q;
		emit      = 1'b0;
		aa        = amino_lookup(held0_q, held1_q, code_s1);
		if (skip_q != 2'd0) begin
			skip_d = skip_q - 2'd1;
		end else if (phase_q != 2'd2) begin
			if (phase_q[0])
				held1_d = code_s1;
			else
				held0_d = code_s1;
			phase_d = phase_q + 2'd1;
		end else begin
			phase_d = 2'd0;
			if (!stopped_q) begin
				if (stop_mode_q && aa == CH_STOP)
					stopped_d = 1'b1;
				else
					emit = 1'b1;
			end
		end
		if (last_s1) begin
			skip_d    = frame_q;
			phase_d   = 2'd0;
			held0_d   = CODE_A;
			held1_d   = CODE_A;
			stopped_d = 1'b0;
		end
	end

	always_comb begin
		res.vld   = vld_s1 && (emit || last_s1);
		res.amino = emit ? aa : 8'd0;
		res.has   = emit;
		res.eos   = last_s1;
	end

	assign adv = vld_s1 && (!res.vld || out_rdy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q     <= 2'd0;
			stop_mode_q <= 1'b0;
			skip_q      <= 2'd0;
			phase_q     <= 2'd0;
			held0_q     <= CODE_A;
			held1_q     <= CODE_A;
			stopped_q   <= 1'b0;
		end else begin
			if (adv) begin
				skip_q    <= skip_d;
				phase_q   <= phase_d;
				held0_q   <= held0_d;
				held1_q   <= held1_d;
				stopped_q <= stopped_d;
			end
			// the user must write only while idle (the block itself does not enforce it); a frame write reloads the skip count
			if (cfg.en && cfg.idx == REG_FRAME) begin
				frame_q <= frame_sat;
				skip_q  <= frame_sat;
			end
			if (cfg.en && cfg.idx == REG_STOP)
				stop_mode_q <= cfg.data[0];
		end
	end

endmodule

// ===== hdl/cata_out_reg.sv =====
module cata_out_reg
	import cata_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  res_t       res,
	input  logic       stall,
	output logic       rdy,
	output logic       valid,
	output logic [7:0] amino_acid,
	output logic       has_residue,
	output logic       end_of_sequence
);

	logic vld_q;

	assign rdy   = !vld_q || !stall;
	assign valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else if (rdy)
			vld_q <= res.vld;
	end

	always_ff @(posedge clk) begin
		if (rdy && res.vld) begin
			amino_acid      <= res.amino;
			has_residue     <= res.has;
			end_of_sequence <= res.eos;
		end
	end

endmodule

// ===== hdl/codon_to_amino_acid_translator.sv =====
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------------
// base in   | base_valid / base_stall    | base_char[7:0], last_base
// amino out | amino_valid / amino_stall  | amino_acid[7:0], has_residue, end_of_sequence
// config    | cfg_valid / cfg_ready      | cfg_index (0 frame, 1 stop mode), cfg_data[1:0]
//
// One base word per cycle sustained while amino_stall is low. A base is encoded
// into the input register, then the codon state and the 64-entry code lookup
// update it into the output register, which drives amino_valid.
// arst_n clears the frame (0), stop mode (0), codon state and both valid flags.
// amino_stall holds the output word; the input register keeps taking bases that
// make no word, and base_stall rises only when a word is blocked behind it.
// cfg_ready is always high; write only while the block is idle.
module codon_to_amino_acid_translator
	import cata_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// base channel
	input  logic       base_valid,
	output logic       base_stall,
	input  logic [7:0] base_char,
	input  logic       last_base,
	// amino acid channel
	output logic       amino_valid,
	input  logic       amino_stall,
	output logic [7:0] amino_acid,
	output logic       has_residue,
	output logic       end_of_sequence,
	// configuration channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data
);

	logic       vld_s1;
	base_code_t code_s1;
	logic       last_s1;
	logic       adv;
	logic       out_rdy;
	res_t       res;
	cfg_wr_t    cfg;
	logic       take;

	assign cfg_ready = 1'b1;

	always_comb begin
		cfg.en   = cfg_valid && cfg_ready;
		cfg.idx  = cfg_index;
		cfg.data = cfg_data;
	end

	// input register is refilled or emptied when its base is absorbed by the codon stage
	assign base_stall = vld_s1 && !adv;
	assign take       = base_valid && !base_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (!base_stall)
			vld_s1 <= base_valid;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			code_s1 <= base_encode(base_char);
			last_s1 <= last_base;
		end
	end

	cata_codon u_codon (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.vld_s1  (vld_s1),
		.code_s1 (code_s1),
		.last_s1 (last_s1),
		.out_rdy (out_rdy),
		.adv     (adv),
		.res     (res)
	);

	cata_out_reg u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.res             (res),
		.stall           (amino_stall),
		.rdy             (out_rdy),
		.valid           (amino_valid),
		.amino_acid      (amino_acid),
		.has_residue     (has_residue),
		.end_of_sequence (end_of_sequence)
	);

endmodule

// ===== hdl/cata_chk.sv =====
module cata_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       amino_valid,
	input logic       amino_stall,
	input logic [7:0] amino_acid,
	input logic       has_residue,
	input logic       end_of_sequence
);

	// blocked word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		amino_valid && amino_stall |=> amino_valid && $stable(amino_acid)
		&& $stable(has_residue) && $stable(end_of_sequence))
		else $error("output word changed while stalled");

	// a word without a residue only exists to close a sequence
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		amino_valid && !has_residue |-> end_of_sequence)
		else $error("empty word without end_of_sequence");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		amino_valid && !has_residue |-> amino_acid == 8'd0)
		else $error("empty word carries a nonzero letter");

	a_residue_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		amino_valid && has_residue |-> amino_acid != 8'd0)
		else $error("residue word carries zero");

endmodule

bind codon_to_amino_acid_translator cata_chk u_cata_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.amino_valid     (amino_valid),
	.amino_stall     (amino_stall),
	.amino_acid      (amino_acid),
	.has_residue     (has_residue),
	.end_of_sequence (end_of_sequence)
);
